// File: rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DataW = 32;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Command broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_MATCH,
    OP_REMOVE
  } cell_op_e;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] value;
    logic [DataW-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e         op;
    logic [DataW-1:0] value;
    logic [DataW-1:0] prio;
  } cell_ctrl_t;

endpackage

// File: rtl/core/spq_req_if.sv
interface spq_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic signed [spq_pkg::DataW-1:0] item_value;
  logic signed [spq_pkg::DataW-1:0] item_priority;

  modport source (output valid, output req_type, output item_value,
                  output item_priority, input ready);
  modport sink (input valid, input req_type, input item_value,
                input item_priority, output ready);
endinterface

// File: rtl/core/spq_rsp_if.sv
interface spq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [spq_pkg::DataW-1:0] out_value;
  logic signed [spq_pkg::DataW-1:0] out_priority;

  modport source (output valid, output status, output out_value,
                  output out_priority, input ready);
  modport sink (input valid, input status, input out_value,
                input out_priority, output ready);
endinterface

// File: rtl/core/spq_cell.sv
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  input  logic                left_ge_i,
  input  logic                shift_i,
  output spq_pkg::entry_t     entry_o,
  output logic                ge_o,
  output logic                match_o
);

  spq_pkg::entry_t entry_q, entry_d;
  logic            match_q, match_d;

  // Entry stays ahead of a new one whose priority is not higher
  assign ge_o    = entry_q.valid && ($signed(entry_q.prio) >= $signed(ctrl_i.prio));
  assign entry_o = entry_q;
  assign match_o = match_q;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    case (ctrl_i.op)
      spq_pkg::OP_INSERT: begin
        if (!ge_o) begin
          if (left_ge_i) begin
            entry_d = '{valid: 1'b1, value: ctrl_i.value, prio: ctrl_i.prio};
          end else begin
            entry_d = left_i;
          end
        end
      end
      spq_pkg::OP_POP: begin
        entry_d = right_i;
      end
      spq_pkg::OP_MATCH: begin
        match_d = entry_q.valid && (entry_q.value == ctrl_i.value);
      end
      spq_pkg::OP_REMOVE: begin
        if (shift_i) begin
          entry_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      match_q <= 1'b0;
    end else begin
      entry_q <= entry_d;
      match_q <= match_d;
    end
  end

endmodule

// File: rtl/core/spq_first_match.sv
module spq_first_match #(
  parameter int unsigned N = 16
) (
  input  logic [N-1:0]    match_i,
  input  spq_pkg::entry_t entries_i [N],
  output logic [N-1:0]    shift_o,
  output logic            any_o,
  output spq_pkg::entry_t sel_o
);

  localparam int unsigned Lvls = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] pre [Lvls+1];
  logic [N-1:0] first;

  assign pre[0] = match_i;

  // Log-depth prefix OR: bit i set when any match at or before cell i
  for (genvar l = 0; l < Lvls; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
      end else begin : g_pass
        assign pre[l+1][i] = pre[l][i];
      end
    end
  end

  assign shift_o = pre[Lvls];
  assign any_o   = |match_i;
  assign first   = match_i & ~{pre[Lvls][N-2:0], 1'b0};

  always_comb begin
    sel_o = '0;
    for (int i = 0; i < N; i++) begin
      sel_o = sel_o | ({$bits(spq_pkg::entry_t){first[i]}} & entries_i[i]);
    end
  end

endmodule

// File: rtl/core/stable_priority_queue_top.sv
// Result words: insert, pop and unused codes give their result word in the cycle after acceptance;
// delete first latches the cell compare, then does first-match select and shift.
// Throughput: one request per cycle for insert and pop while each result word is taken at once;
// a delete blocks the request side while the match flags settle in the cells.
// Reset: rst_ni clears the entry count, all cell valid bits and the output register;
// the queue takes requests as soon as reset is released.
module stable_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_DELETE
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q;
  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [spq_pkg::DataW-1:0] value_q;
  logic [spq_pkg::DataW-1:0] prio_q;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] shift;
  logic                any_hit;
  spq_pkg::entry_t     sel_entry;

  logic in_acc;
  logic out_free;
  logic full;
  logic empty;

  assign full     = (count_q == CntW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign out_free = !out_valid_q || rsp_o.ready;
  // Hold off requests while a delete is resolving or a result word waits
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc      = req_i.valid && req_i.ready;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_value    = value_q;
  assign rsp_o.out_priority = prio_q;

  // Command broadcast: one op for the whole row each cycle
  always_comb begin
    ctrl.op    = spq_pkg::OP_HOLD;
    ctrl.value = req_i.item_value;
    ctrl.prio  = req_i.item_priority;
    if (in_acc) begin
      case (req_i.req_type)
        spq_pkg::REQ_INSERT: if (!full)  ctrl.op = spq_pkg::OP_INSERT;
        spq_pkg::REQ_POP:    if (!empty) ctrl.op = spq_pkg::OP_POP;
        spq_pkg::REQ_DELETE: if (!empty) ctrl.op = spq_pkg::OP_MATCH;
        default: ctrl.op = spq_pkg::OP_HOLD;
      endcase
    end else if (state_q == S_DELETE && out_free && any_hit) begin
      ctrl.op = spq_pkg::OP_REMOVE;
    end
  end

  // Row of cells: slot 0 is the head; insert shifts right, removal shifts left
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_ge;

    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_ge = 1'b1;
    end else begin : g_body
      assign left_e  = cell_entry[i-1];
      assign left_ge = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_e),
      .right_i   (right_e),
      .left_ge_i (left_ge),
      .shift_i   (shift[i]),
      .entry_o   (cell_entry[i]),
      .ge_o      (cell_ge[i]),
      .match_o   (cell_match[i])
    );

    assign cell_valid[i] = cell_entry[i].valid;
  end

  // First matching cell: cells from it onward pull from the right
  spq_first_match #(
    .N (CAPACITY)
  ) u_first_match (
    .match_i   (cell_match),
    .entries_i (cell_entry),
    .shift_o   (shift),
    .any_o     (any_hit),
    .sel_o     (sel_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= spq_pkg::ST_OK;
      value_q     <= '0;
      prio_q      <= '0;
    end else begin
      if (rsp_o.valid && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        case (req_i.req_type)
          spq_pkg::REQ_INSERT: begin
            out_valid_q <= 1'b1;
            value_q     <= '0;
            prio_q      <= '0;
            if (full) begin
              status_q <= spq_pkg::ST_FULL;
            end else begin
              status_q <= spq_pkg::ST_OK;
              count_q  <= count_q + CntW'(1);
            end
          end
          spq_pkg::REQ_POP: begin
            out_valid_q <= 1'b1;
            if (empty) begin
              status_q <= spq_pkg::ST_EMPTY;
              value_q  <= '0;
              prio_q   <= '0;
            end else begin
              status_q <= spq_pkg::ST_OK;
              value_q  <= cell_entry[0].value;
              prio_q   <= cell_entry[0].prio;
              count_q  <= count_q - CntW'(1);
            end
          end
          spq_pkg::REQ_DELETE: begin
            if (empty) begin
              out_valid_q <= 1'b1;
              status_q    <= spq_pkg::ST_EMPTY;
              value_q     <= '0;
              prio_q      <= '0;
            end else begin
              // Cells latch their compare now; resolve next cycle
              state_q <= S_DELETE;
            end
          end
          default: begin
            out_valid_q <= 1'b1;
            status_q    <= spq_pkg::ST_OK;
            value_q     <= '0;
            prio_q      <= '0;
          end
        endcase
      end else if (state_q == S_DELETE && out_free) begin
        state_q     <= S_IDLE;
        out_valid_q <= 1'b1;
        if (any_hit) begin
          status_q <= spq_pkg::ST_OK;
          value_q  <= sel_entry.value;
          prio_q   <= sel_entry.prio;
          count_q  <= count_q - CntW'(1);
        end else begin
          status_q <= spq_pkg::ST_NOT_FOUND;
          value_q  <= '0;
          prio_q   <= '0;
        end
      end
    end
  end

  // Count never runs past the row
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Occupied cells always agree with the entry count
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(count_q))
    else $error("cell valid bits disagree with entry count");

  // No new request while a delete is resolving
  a_delete_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DELETE) |-> !req_i.ready)
    else $error("request accepted during delete");

  // A pop on a non-empty queue drops the count by one
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_i.req_type == spq_pkg::REQ_POP && !empty)
      |=> count_q == $past(count_q) - CntW'(1))
    else $error("pop did not shrink the queue");

endmodule

// File: bench/tb_stable_priority_queue_top.sv
module tb_stable_priority_queue_top;

  localparam int unsigned QUEUE_DEPTH = 16;
  // Code 3 has no name in the package; the block treats it as a no-op.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_BLOCKS = 23;
  localparam int unsigned BLOCK_ITEMS = 50;

  typedef struct {
    logic [1:0]                       status;
    logic signed [spq_pkg::DataW-1:0] value;
    logic signed [spq_pkg::DataW-1:0] prio;
  } result_word_t;

  // Mirror of the sorted store: slot 0 is the head. Requests are applied
  // in acceptance order and each one queues exactly one expected word.
  class prio_queue_mirror;
    logic signed [spq_pkg::DataW-1:0] slot_value[QUEUE_DEPTH];
    logic signed [spq_pkg::DataW-1:0] slot_prio[QUEUE_DEPTH];
    int unsigned                      fill_level;
    result_word_t                     pending_words[$];
    int unsigned                      fail_count;

    function new();
      fill_level = 0;
      fail_count = 0;
    endfunction

    // Take the entry at slot and close the gap behind it.
    function void take_at(int unsigned slot, output result_word_t word);
      int unsigned i;
      word.status = spq_pkg::ST_OK;
      word.value  = slot_value[slot];
      word.prio   = slot_prio[slot];
      for (i = slot; i + 1 < fill_level; i++) begin
        slot_value[i] = slot_value[i + 1];
        slot_prio[i]  = slot_prio[i + 1];
      end
      fill_level--;
    endfunction

    function void apply_request(logic [1:0] kind, logic signed [spq_pkg::DataW-1:0] value,
                                logic signed [spq_pkg::DataW-1:0] prio);
      result_word_t word;
      int unsigned  slot;
      int unsigned  i;
      word.status = spq_pkg::ST_OK;
      word.value  = '0;
      word.prio   = '0;
      case (kind)
        spq_pkg::REQ_INSERT: begin
          if (fill_level >= QUEUE_DEPTH) begin
            word.status = spq_pkg::ST_FULL;
          end else begin
            // Go behind every entry of equal or higher priority.
            slot = 0;
            while (slot < fill_level && slot_prio[slot] >= prio) slot++;
            for (i = fill_level; i > slot; i--) begin
              slot_value[i] = slot_value[i - 1];
              slot_prio[i]  = slot_prio[i - 1];
            end
            slot_value[slot] = value;
            slot_prio[slot]  = prio;
            fill_level++;
          end
        end
        spq_pkg::REQ_POP: begin
          if (fill_level == 0) word.status = spq_pkg::ST_EMPTY;
          else take_at(0, word);
        end
        spq_pkg::REQ_DELETE: begin
          if (fill_level == 0) begin
            word.status = spq_pkg::ST_EMPTY;
          end else begin
            slot = 0;
            while (slot < fill_level && slot_value[slot] != value) slot++;
            if (slot >= fill_level) word.status = spq_pkg::ST_NOT_FOUND;
            else take_at(slot, word);
          end
        end
        default: ;
      endcase
      pending_words.push_back(word);
    endfunction

    function void check_result(logic [1:0] status, logic signed [spq_pkg::DataW-1:0] value,
                               logic signed [spq_pkg::DataW-1:0] prio);
      result_word_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected result word: status %0d out_value %0d out_priority %0d",
               status, value, prio);
        fail_count++;
        return;
      end
      want = pending_words.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        fail_count++;
      end
      if (value !== want.value) begin
        $error("out_value: expected %0d, actual %0d", want.value, value);
        fail_count++;
      end
      if (prio !== want.prio) begin
        $error("out_priority: expected %0d, actual %0d", want.prio, prio);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   send_idle = 1'b1;
  bit   recv_idle = 1'b1;
  int unsigned quiet_cycles;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  prio_queue_mirror mirror = new();

  stable_priority_queue_top #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive one request word and hold it until the block takes it. Keep valid
  // high across back-to-back words; drop it only for a drawn gap.
  task automatic send_request(input logic [1:0] kind,
                              input logic signed [spq_pkg::DataW-1:0] value,
                              input logic signed [spq_pkg::DataW-1:0] prio);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.item_value    <= value;
    req_if.item_priority <= prio;
    do @(posedge clk); while (!req_if.ready);
    mirror.apply_request(kind, value, prio);
  endtask

  // Drop valid and hold off until every expected word has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending_words.size() != 0) @(posedge clk);
  endtask

  // Mostly small values so that deletes hit and duplicates occur; the rest
  // full-width random words and the extremes.
  function automatic logic signed [spq_pkg::DataW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return $urandom_range(0, 7);
    if (roll < 8) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Narrow band around zero gives many ties, which exercises arrival order.
  function automatic logic signed [spq_pkg::DataW-1:0] pick_prio();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return $signed($urandom_range(0, 6)) - 3;
    if (roll < 9) return $urandom();
    return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
  endfunction

  // Aim most deletes at a stored value, first match counted from the head.
  function automatic logic signed [spq_pkg::DataW-1:0] pick_victim();
    if (mirror.fill_level > 0 && $urandom_range(0, 9) < 7)
      return mirror.slot_value[$urandom_range(0, mirror.fill_level - 1)];
    return pick_value();
  endfunction

  // Response side: draw a stall per word, keep ready high when none.
  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      mirror.check_result(rsp_if.status, rsp_if.out_value, rsp_if.out_priority);
    end
  end

  // Watchdog: count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned blk;
    int unsigned n;
    int unsigned bias;
    int unsigned roll;
    int unsigned ins_cut;
    int unsigned pop_cut;
    int unsigned del_cut;
    rst_n                <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= spq_pkg::REQ_INSERT;
    req_if.item_value    <= '0;
    req_if.item_priority <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue: pop and delete report empty, the unused code is a no-op.
    send_request(spq_pkg::REQ_POP, 0, 0);
    send_request(spq_pkg::REQ_DELETE, 5, 0);
    send_request(REQ_UNUSED, '1, '1);

    // Fill to capacity: ties at zero, at both extremes and in between,
    // plus the value 7 three times at different priorities.
    send_request(spq_pkg::REQ_INSERT, 10, 0);
    send_request(spq_pkg::REQ_INSERT, 11, 0);
    send_request(spq_pkg::REQ_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_request(spq_pkg::REQ_INSERT, 32'sh8000_0000, 32'sh8000_0000);
    send_request(spq_pkg::REQ_INSERT, 12, 0);
    send_request(spq_pkg::REQ_INSERT, 7, -1);
    send_request(spq_pkg::REQ_INSERT, 7, 5);
    send_request(spq_pkg::REQ_INSERT, 0, 32'sh7fff_ffff);
    send_request(spq_pkg::REQ_INSERT, -1, 32'sh8000_0000);
    send_request(spq_pkg::REQ_INSERT, 13, 3);
    send_request(spq_pkg::REQ_INSERT, 14, 3);
    send_request(spq_pkg::REQ_INSERT, 15, -2);
    send_request(spq_pkg::REQ_INSERT, 16, 1);
    send_request(spq_pkg::REQ_INSERT, 17, 1);
    send_request(spq_pkg::REQ_INSERT, 18, 0);
    send_request(spq_pkg::REQ_INSERT, 7, 32'sh7fff_fffe);

    // Full queue: drop the insert, then no-op, miss, first-match delete, pop.
    send_request(spq_pkg::REQ_INSERT, 99, 1);
    send_request(REQ_UNUSED, 0, 0);
    send_request(spq_pkg::REQ_DELETE, 1234, 0);
    send_request(spq_pkg::REQ_DELETE, 7, 0);
    send_request(spq_pkg::REQ_POP, 0, 0);
    drain_results();

    // Random blocks: each leans toward filling, draining or a balanced mix,
    // so the occupancy sweeps from empty to full many times over.
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      bias      = $urandom_range(0, 2);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      case (bias)
        0:       begin ins_cut = 70; pop_cut = 80; del_cut = 95; end
        1:       begin ins_cut = 20; pop_cut = 65; del_cut = 95; end
        default: begin ins_cut = 45; pop_cut = 70; del_cut = 95; end
      endcase
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_cut)
          send_request(spq_pkg::REQ_INSERT, pick_value(), pick_prio());
        else if (roll < pop_cut)
          send_request(spq_pkg::REQ_POP, $urandom(), $urandom());
        else if (roll < del_cut)
          send_request(spq_pkg::REQ_DELETE, pick_victim(), $urandom());
        else
          send_request(REQ_UNUSED, $urandom(), $urandom());
      end
      if (blk % 5 == 4) drain_results();
    end

    // Wait out the last words, then wait on for any stray one.
    drain_results();
    repeat (6) @(posedge clk);
    if (mirror.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
